@@ hdl/assert_macros.svh @@
// Assertion helpers shared by the RTL; all are clocked on clk and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define LCTG_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// Next-cycle implication.
`define LCTG_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

@@ hdl/lctg_pkg.sv @@
`default_nettype none

package lctg_pkg;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef enum logic [2:0] {
    REG_DIRECTION = 3'd0,
    REG_PERIOD    = 3'd1,
    REG_RED       = 3'd2,
    REG_GREEN     = 3'd3,
    REG_BLUE      = 3'd4,
    REG_TRAIL     = 3'd5,
    REG_STRIP     = 3'd6
  } cfg_reg_t;

  localparam int unsigned MaxLeds  = 256;
  localparam int unsigned MaxTrail = 64;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned TrailW   = 7;
  localparam int unsigned StripW   = 9;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned IdxW     = 8;
  localparam int unsigned TW       = 6;

  localparam logic [7:0]        FullBright   = 8'd255;
  localparam logic [15:0]       PeriodReset  = 16'd500;
  localparam logic [TrailW-1:0] TrailReset   = 7'd2;
  localparam logic [StripW-1:0] StripReset   = 9'd256;
  localparam logic [StripW-1:0] StripMax     = 9'd256;
  localparam logic [TrailW-1:0] TrailMax     = 7'd64;

  // Brightness decrement per trail pixel, floor(255 / L), indexed by L - 1.
  localparam logic [7:0] STEP_TABLE [64] = '{
    8'd255, 8'd127, 8'd85,  8'd63,  8'd51,  8'd42,  8'd36,  8'd31,
    8'd28,  8'd25,  8'd23,  8'd21,  8'd19,  8'd18,  8'd17,  8'd15,
    8'd15,  8'd14,  8'd13,  8'd12,  8'd12,  8'd11,  8'd11,  8'd10,
    8'd10,  8'd9,   8'd9,   8'd9,   8'd8,   8'd8,   8'd8,   8'd7,
    8'd7,   8'd7,   8'd7,   8'd7,   8'd6,   8'd6,   8'd6,   8'd6,
    8'd6,   8'd6,   8'd5,   8'd5,   8'd5,   8'd5,   8'd5,   8'd5,
    8'd5,   8'd5,   8'd5,   8'd4,   8'd4,   8'd4,   8'd4,   8'd4,
    8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd3
  };

endpackage

`default_nettype wire

@@ hdl/lctg_dim.sv @@
`default_nettype none

module lctg_dim (
  input  lctg_pkg::rgb_t level,
  input  logic [7:0]     bright,
  output lctg_pkg::rgb_t dimmed
);
  import lctg_pkg::*;

  // x / 255 for x up to 255*255: (x + 1 + (x >> 8)) >> 8
  function automatic logic [7:0] scale(input logic [7:0] lvl, input logic [7:0] b);
    logic [15:0] prod;
    logic [16:0] sum;
    prod = {8'd0, lvl} * {8'd0, b};
    sum  = {1'b0, prod} + 17'd1 + {9'd0, prod[15:8]};
    return sum[15:8];
  endfunction

  assign dimmed.red   = scale(level.red,   bright);
  assign dimmed.green = scale(level.green, bright);
  assign dimmed.blue  = scale(level.blue,  bright);

endmodule

`default_nettype wire

@@ hdl/led_chase_trail_generator_unit.sv @@
// LED chase with a fading trail.
// Input channel (in_valid / in_stall / in_now_ms): one millisecond timestamp per item.
// If at least period_ms have passed since the last frame, the block records the
// time and sends one frame of L pixels on the output channel, L = min(trail_length,
// strip_length, 64), a zero strip counting as one; otherwise the item produces nothing.
// Output channel (out_valid / out_stall / out_*): head pixel first with clear_first
// set, last pixel with frame_done set; the head then steps one LED with wrap.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): always ready, write
// only while idle. A zero trail length write is ignored.
// Timing: an item is accepted in the idle state and its time tested in the check state,
// then one pixel goes out per cycle while the output is not stalled, from a single
// shared dim unit (three 8x8 multiplies); the input is stalled until the last pixel
// is in the output register. A stalled output holds its pixel and pauses the walk.
// Reset: registers return to their defaults, last frame time and head go to zero,
// the output register empties.
`default_nettype none
`include "assert_macros.svh"

module led_chase_trail_generator_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [lctg_pkg::TimeW-1:0]        in_now_ms,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [lctg_pkg::IdxW-1:0]         out_led_index,
  output logic [7:0]                        out_red_out,
  output logic [7:0]                        out_green_out,
  output logic [7:0]                        out_blue_out,
  output logic                              out_clear_first,
  output logic                              out_frame_done,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lctg_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [lctg_pkg::CfgDataW-1:0]     cfg_data
);
  import lctg_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CHECK = 3'b010,
    S_EMIT  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic              dir_fwd_r;
  logic [15:0]       period_r;
  rgb_t              color_r;
  logic [TrailW-1:0] trail_r;
  logic [StripW-1:0] strip_r;

  logic [TimeW-1:0]  last_r, last_nxt;
  logic [IdxW-1:0]   head_r, head_nxt;
  logic [TimeW-1:0]  now_r;

  logic [IdxW-1:0]   nm1_r, nm1_nxt;
  logic [TW-1:0]     lenm1_r, lenm1_nxt;
  logic [TW-1:0]     t_r, t_nxt;
  logic [IdxW-1:0]   idx_r, idx_nxt;
  logic [7:0]        step_r, step_nxt;
  logic [7:0]        bright_r, bright_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_load;
  logic [IdxW-1:0]   out_idx_r;
  rgb_t              out_rgb_r;
  logic              out_first_r;
  logic              out_last_r;

  logic [TimeW-1:0]  elapsed;
  logic [StripW-1:0] n_eff;
  logic [TrailW-1:0] trail_cap;
  logic [StripW-1:0] len_eff;
  logic [IdxW-1:0]   head_eff;
  logic              out_free;
  logic              last_pix;
  rgb_t              dimmed;

  lctg_dim u_dim (
    .level  (color_r),
    .bright (bright_r),
    .dimmed (dimmed)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;
  assign last_pix  = (t_r == lenm1_r);

  // Frame geometry, settled in the check cycle.
  always_comb begin
    elapsed = now_r - last_r;
    if (strip_r == '0) begin
      n_eff = StripW'(1);
    end else if (strip_r > StripMax) begin
      n_eff = StripMax;
    end else begin
      n_eff = strip_r;
    end
    trail_cap = (trail_r > TrailMax) ? TrailMax : trail_r;
    len_eff   = ({2'b00, trail_cap} > n_eff) ? n_eff : {2'b00, trail_cap};
    head_eff  = ({1'b0, head_r} >= n_eff) ? '0 : head_r;
  end

  always_comb begin
    state_nxt     = state_r;
    last_nxt      = last_r;
    head_nxt      = head_r;
    nm1_nxt       = nm1_r;
    lenm1_nxt     = lenm1_r;
    t_nxt         = t_r;
    idx_nxt       = idx_r;
    step_nxt      = step_r;
    bright_nxt    = bright_r;
    out_valid_nxt = out_valid_r;
    out_load      = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (elapsed < {16'd0, period_r}) begin
          state_nxt = S_IDLE;
        end else begin
          last_nxt   = now_r;
          nm1_nxt    = IdxW'(n_eff - StripW'(1));
          lenm1_nxt  = TW'(len_eff - StripW'(1));
          step_nxt   = STEP_TABLE[TW'(len_eff - StripW'(1))];
          bright_nxt = FullBright;
          t_nxt      = '0;
          idx_nxt    = head_eff;
          head_nxt   = head_eff;
          state_nxt  = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          t_nxt         = t_r + TW'(1);
          bright_nxt    = bright_r - step_r;
          // Trail walks opposite to the way the head moves.
          if (dir_fwd_r) begin
            idx_nxt = (idx_r == '0) ? nm1_r : idx_r - IdxW'(1);
          end else begin
            idx_nxt = (idx_r == nm1_r) ? '0 : idx_r + IdxW'(1);
          end
          if (last_pix) begin
            if (dir_fwd_r) begin
              head_nxt = (head_r == nm1_r) ? '0 : head_r + IdxW'(1);
            end else begin
              head_nxt = (head_r == '0) ? nm1_r : head_r - IdxW'(1);
            end
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      last_r      <= '0;
      head_r      <= '0;
      dir_fwd_r   <= 1'b1;
      period_r    <= PeriodReset;
      color_r     <= '{red: FullBright, green: FullBright, blue: FullBright};
      trail_r     <= TrailReset;
      strip_r     <= StripReset;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      last_r      <= last_nxt;
      head_r      <= head_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DIRECTION: dir_fwd_r     <= cfg_data[0];
          REG_PERIOD:    period_r      <= cfg_data;
          REG_RED:       color_r.red   <= cfg_data[7:0];
          REG_GREEN:     color_r.green <= cfg_data[7:0];
          REG_BLUE:      color_r.blue  <= cfg_data[7:0];
          REG_TRAIL: begin
            if (cfg_data[TrailW-1:0] != '0) begin
              trail_r <= cfg_data[TrailW-1:0];
            end
          end
          REG_STRIP:     strip_r       <= cfg_data[StripW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      now_r <= in_now_ms;
    end
    nm1_r    <= nm1_nxt;
    lenm1_r  <= lenm1_nxt;
    t_r      <= t_nxt;
    idx_r    <= idx_nxt;
    step_r   <= step_nxt;
    bright_r <= bright_nxt;
    if (out_load) begin
      out_idx_r   <= idx_r;
      out_rgb_r   <= dimmed;
      out_first_r <= (t_r == '0);
      out_last_r  <= last_pix;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_led_index   = out_idx_r;
  assign out_red_out     = out_rgb_r.red;
  assign out_green_out   = out_rgb_r.green;
  assign out_blue_out    = out_rgb_r.blue;
  assign out_clear_first = out_first_r;
  assign out_frame_done  = out_last_r;

  `LCTG_ASSERT_NOW(a_t_in_range, state_r == S_EMIT, t_r <= lenm1_r, "pixel count past trail")
  `LCTG_ASSERT_NOW(a_idx_in_strip, state_r == S_EMIT, idx_r <= nm1_r, "led index past strip")
  `LCTG_ASSERT_NOW(a_bright_lit, state_r == S_EMIT, bright_r != '0, "trail pixel fully dark")
  `LCTG_ASSERT_NEXT(a_last_ends_frame, state_r == S_EMIT && out_free && last_pix,
                    state_r == S_IDLE && out_valid_r && out_last_r, "frame did not close")

endmodule

`default_nettype wire
